[hdl/line_centroid_pd_steering_unit_macros.svh]
// Assertion macros for the line centroid steering unit checker.
// Used by lcs_checker.sv; needs nothing else.
`ifndef LINE_CENTROID_PD_STEERING_UNIT_MACROS_SVH
`define LINE_CENTROID_PD_STEERING_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("steering unit check failed");

// Consequent must hold in the cycle after the antecedent.
`define LCS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("steering unit check failed");

`endif

[hdl/lcs_pkg.sv]
// Shared types, widths and constants of the line centroid steering unit.
// Depends on nothing; the queue, front end, back end and top level import it.
`default_nettype none

package lcs_pkg;

	localparam int ROW_WIDTH = 320;
	localparam int HALF_ROW = ROW_WIDTH / 2;
	localparam int SUM_MAX = HALF_ROW * (HALF_ROW + 1) / 2;

	localparam int POS_W = $clog2(ROW_WIDTH);
	localparam int CNT_W = $clog2(ROW_WIDTH + 1);
	localparam int SUM_W = $clog2(SUM_MAX + 1) + 1;
	localparam int LIMIT_W = 9;
	localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int MAG_W = 9;
	localparam int QX_W = (SUM_W > MAG_W) ? SUM_W : MAG_W;
	localparam int STEP_W = $clog2(SUM_W);
	localparam int GAIN_W = 16;
	localparam int PROD_W = MAG_W + GAIN_W;
	localparam int DRV_SUM_W = MAG_W + 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_WHITE_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CROWD_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOST_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_SPEED = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_KP_Q16 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_KD_Q16 = 3'd6;

	typedef struct packed {
		logic [7:0]         white_threshold;
		logic [LIMIT_W-1:0] crowd_limit;
		logic [LIMIT_W-1:0] lost_limit;
		logic [6:0]         base_speed;
		logic [6:0]         reverse_speed;
		logic [GAIN_W-1:0]  kp_q16;
		logic [GAIN_W-1:0]  kd_q16;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		white_threshold: 8'd130,
		crowd_limit:     9'd315,
		lost_limit:      9'd20,
		base_speed:      7'd45,
		reverse_speed:   7'd40,
		kp_q16:          16'd13107,
		kd_q16:          16'd1966
	};

	typedef enum logic [1:0] {
		ACT_RIGHT    = 2'd0,
		ACT_LEFT     = 2'd1,
		ACT_REVERSE  = 2'd2,
		ACT_CROSSING = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ROW_FOLLOW = 2'd0,
		ROW_LOST   = 2'd1,
		ROW_CROSS  = 2'd2
	} row_kind_t;

	// Summary of one finished scan line, handed from front to back.
	typedef struct packed {
		row_kind_t               kind;
		logic [CNT_W-1:0]        count;
		logic signed [SUM_W-1:0] sum;
	} row_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SAT,
		ST_MUL,
		ST_EMIT
	} st_t;

endpackage

`default_nettype wire

[hdl/lcs_queue.sv]
// Short row-summary queue between the pixel front end and the control back end.
// Depends on lcs_pkg.
`default_nettype none

module lcs_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  lcs_pkg::row_t     wr_data,
	output logic              full,
	input  wire logic         rd_en,
	output lcs_pkg::row_t     rd_data,
	output logic              empty
);
	import lcs_pkg::*;

	row_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/lcs_front.sv]
// Pixel front end: counts white pixels, sums their offsets and classifies each row.
// Depends on lcs_pkg; feeds lcs_queue.
`default_nettype none

module lcs_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  lcs_pkg::cfg_t     cfg,
	input  wire logic         accept,
	input  wire logic [7:0]   pixel,
	output logic              row_push,
	output lcs_pkg::row_t     row_data
);
	import lcs_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic             white;
	logic             last;
	logic [SUM_W-1:0] offs;
	logic [SUM_W-1:0] sum_nx;
	logic [CNT_W-1:0] cnt_nx;
	logic [CMP_W-1:0] cnt_cmp;
	logic             crowd;
	logic             lost;

	always_comb begin
		white = pixel > cfg.white_threshold;
		last = (pos_q == POS_W'(ROW_WIDTH - 1));
		offs = {{(SUM_W - POS_W){1'b0}}, pos_q} - SUM_W'(HALF_ROW);
		sum_nx = white ? sum_q + offs : sum_q;
		cnt_nx = cnt_q + CNT_W'(white);
		cnt_cmp = CMP_W'(cnt_nx);
		crowd = cnt_cmp > CMP_W'(cfg.crowd_limit);
		lost = cnt_cmp < CMP_W'(cfg.lost_limit);
		// An empty row that is not lost produces nothing downstream.
		row_push = accept && last && (crowd || lost || (cnt_nx != '0));
		row_data.kind = crowd ? ROW_CROSS : (lost ? ROW_LOST : ROW_FOLLOW);
		row_data.count = cnt_nx;
		row_data.sum = $signed(sum_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cnt_q <= '0;
			sum_q <= '0;
		end else if (accept) begin
			if (last) begin
				pos_q <= '0;
				cnt_q <= '0;
				sum_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
				cnt_q <= cnt_nx;
				sum_q <= sum_nx;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/lcs_back.sv]
// Control back end: divides the offset sum by the count, forms the PD drives and
// holds the result word until it is taken. Depends on lcs_pkg; reads lcs_queue.
`default_nettype none

module lcs_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  lcs_pkg::cfg_t            cfg,
	input  wire logic                q_empty,
	input  lcs_pkg::row_t            q_data,
	output logic                     q_pop,
	output logic                     empty,
	input  wire logic                pop,
	output logic [1:0]               action,
	output logic signed [7:0]        left_drive,
	output logic signed [7:0]        right_drive,
	output logic signed [8:0]        line_offset
);
	import lcs_pkg::*;

	st_t                     state_q;
	st_t                     state_nx;
	row_kind_t               kind_q;
	logic                    neg_q;
	logic [CNT_W-1:0]        div_q;
	logic [CNT_W+SUM_W-1:0]  dq_q;
	logic [STEP_W-1:0]       step_q;
	logic [MAG_W-1:0]        mag_q;
	logic [MAG_W-1:0]        diff_q;
	logic [MAG_W-1:0]        pmag_q;
	logic [MAG_W-1:0]        dmag_q;
	logic [7:0]              prev_err_q;
	logic                    out_valid_q;
	logic [1:0]              act_q;
	logic [7:0]              left_q;
	logic [7:0]              right_q;
	logic [8:0]              offs_q;

	logic [SUM_W-1:0]        abs_sum;
	logic [CNT_W:0]          trial;
	logic [CNT_W-1:0]        rem_nx;
	logic                    qbit;
	logic [QX_W-1:0]         quo_x;
	logic [MAG_W-1:0]        mag_nx;
	logic [MAG_W-1:0]        prev_x;
	logic [PROD_W-1:0]       pprod;
	logic [PROD_W-1:0]       dprod;
	logic [DRV_SUM_W-1:0]    drv_sum;
	logic [6:0]              drv_sat;
	logic                    slot_free;
	logic                    emit_want;
	logic                    emit_fire;
	logic [1:0]              act_nx;
	logic [7:0]              left_nx;
	logic [7:0]              right_nx;
	logic [8:0]              offs_nx;

	// Datapath helpers.
	always_comb begin
		abs_sum = q_data.sum[SUM_W-1] ? -q_data.sum : q_data.sum;
		trial = {dq_q[CNT_W+SUM_W-1 -: CNT_W], dq_q[SUM_W-1]};
		qbit = trial >= {1'b0, div_q};
		rem_nx = qbit ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
		quo_x = QX_W'(dq_q[SUM_W-1:0]);
		// Saturate the quotient to the range -256..255 of the mean offset.
		if (neg_q) begin
			mag_nx = (quo_x > QX_W'(256)) ? MAG_W'(256) : quo_x[MAG_W-1:0];
		end else begin
			mag_nx = (quo_x > QX_W'(255)) ? MAG_W'(255) : quo_x[MAG_W-1:0];
		end
		prev_x = {1'b0, prev_err_q};
		pprod = mag_q * cfg.kp_q16;
		dprod = diff_q * cfg.kd_q16;
		drv_sum = DRV_SUM_W'(cfg.base_speed) + DRV_SUM_W'(pmag_q) + DRV_SUM_W'(dmag_q);
		drv_sat = (drv_sum > DRV_SUM_W'(127)) ? 7'd127 : drv_sum[6:0];
		slot_free = !out_valid_q || pop;
	end

	// Result word formed in the emit state.
	always_comb begin
		emit_want = 1'b1;
		act_nx = ACT_CROSSING;
		left_nx = '0;
		right_nx = '0;
		offs_nx = '0;
		case (kind_q)
			ROW_CROSS: begin
				act_nx = ACT_CROSSING;
			end
			ROW_LOST: begin
				act_nx = ACT_REVERSE;
				left_nx = -{1'b0, cfg.reverse_speed};
				right_nx = {1'b0, cfg.reverse_speed};
			end
			ROW_FOLLOW: begin
				emit_want = (pmag_q != '0);
				if (!neg_q) begin
					act_nx = ACT_RIGHT;
					left_nx = {1'b0, drv_sat};
					right_nx = -{1'b0, cfg.base_speed};
					offs_nx = mag_q;
				end else begin
					act_nx = ACT_LEFT;
					left_nx = {1'b0, cfg.base_speed};
					right_nx = -{1'b0, drv_sat};
					offs_nx = -mag_q;
				end
			end
			default: begin
				emit_want = 1'b0;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					state_nx = (q_data.kind == ROW_FOLLOW) ? ST_DIV : ST_EMIT;
				end
			end
			ST_DIV: begin
				if (step_q == STEP_W'(SUM_W - 1)) begin
					state_nx = ST_SAT;
				end
			end
			ST_SAT: begin
				state_nx = ST_MUL;
			end
			ST_MUL: begin
				state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (!emit_want || slot_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Control outputs.
	always_comb begin
		q_pop = 1'b0;
		emit_fire = 1'b0;
		case (state_q)
			ST_IDLE: begin
				q_pop = !q_empty;
			end
			ST_EMIT: begin
				emit_fire = emit_want && slot_free;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prev_err_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_MUL) begin
				prev_err_q <= (mag_q > MAG_W'(255)) ? 8'd255 : mag_q[7:0];
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q <= q_data.kind;
			neg_q <= q_data.sum[SUM_W-1];
			div_q <= q_data.count;
			dq_q <= {{CNT_W{1'b0}}, abs_sum};
			step_q <= '0;
		end
		if (state_q == ST_DIV) begin
			dq_q <= {rem_nx, dq_q[SUM_W-2:0], qbit};
			step_q <= step_q + 1'b1;
		end
		if (state_q == ST_SAT) begin
			mag_q <= mag_nx;
			diff_q <= (mag_nx > prev_x) ? mag_nx - prev_x : prev_x - mag_nx;
		end
		if (state_q == ST_MUL) begin
			pmag_q <= pprod[PROD_W-1 -: MAG_W];
			dmag_q <= dprod[PROD_W-1 -: MAG_W];
		end
		if (emit_fire) begin
			act_q <= act_nx;
			left_q <= left_nx;
			right_q <= right_nx;
			offs_q <= offs_nx;
		end
	end

	assign empty = !out_valid_q;
	assign action = act_q;
	assign left_drive = $signed(left_q);
	assign right_drive = $signed(right_q);
	assign line_offset = $signed(offs_q);

endmodule

`default_nettype wire

[hdl/line_centroid_pd_steering_unit.sv]
// Top level of the line centroid steering unit: configuration registers and the
// front end, row queue and back end. Depends on lcs_pkg and the lcs_* modules.
//
// Pixels of one scan line enter on pixel with push; a word is taken when push is
// high and full is low. Full rises only while the row queue holds two finished
// rows, so pixels normally stream at one per cycle.
// After the last pixel of a row, one result word may appear on action,
// left_drive, right_drive and line_offset while empty is low; pop takes it.
// A crossing or lost row skips the divider and goes straight to the emit state.
// A followed row runs a one-bit-per-cycle divider of SUM_W steps (15 at a row
// width of 320), then a saturate state and a state for the gain multiplies.
// Rows with a zero proportional term, and empty rows that are not lost, give no
// word. While the receiver holds off pop, the word stays put; the back end then
// stalls and the queue fills, and only after that does full stall the pixels.
// Configuration writes on cfg_valid/cfg_index/cfg_data are always taken
// (cfg_ready is high) and belong in idle periods. Reset returns all configuration
// registers to their defaults and clears the row counters and the stored error.
`default_nettype none

module line_centroid_pd_steering_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [7:0]                     pixel,
	output logic                                empty,
	input  wire logic                           pop,
	output logic [1:0]                          action,
	output logic signed [7:0]                   left_drive,
	output logic signed [7:0]                   right_drive,
	output logic signed [8:0]                   line_offset,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [lcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lcs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lcs_pkg::*;

	cfg_t cfg_q;
	logic accept;
	logic row_push;
	row_t row_data;
	logic q_full;
	logic q_empty;
	logic q_pop;
	row_t q_data;

	assign cfg_ready = 1'b1;
	assign full = q_full;
	assign accept = push && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WHITE_THRESHOLD: cfg_q.white_threshold <= cfg_data[7:0];
				CFG_CROWD_LIMIT:     cfg_q.crowd_limit <= cfg_data[LIMIT_W-1:0];
				CFG_LOST_LIMIT:      cfg_q.lost_limit <= cfg_data[LIMIT_W-1:0];
				CFG_BASE_SPEED:      cfg_q.base_speed <= cfg_data[6:0];
				CFG_REVERSE_SPEED:   cfg_q.reverse_speed <= cfg_data[6:0];
				CFG_KP_Q16:          cfg_q.kp_q16 <= cfg_data[GAIN_W-1:0];
				CFG_KD_Q16:          cfg_q.kd_q16 <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	lcs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.accept   (accept),
		.pixel    (pixel),
		.row_push (row_push),
		.row_data (row_data)
	);

	lcs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (row_push),
		.wr_data (row_data),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	lcs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_empty     (q_empty),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.action      (action),
		.left_drive  (left_drive),
		.right_drive (right_drive),
		.line_offset (line_offset)
	);

endmodule

`default_nettype wire

[hdl/lcs_checker.sv]
// Port-level checks of the line centroid steering unit, bound to its top level.
// Depends on line_centroid_pd_steering_unit_macros.svh.
`default_nettype none

`include "line_centroid_pd_steering_unit_macros.svh"

module lcs_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       empty,
	input  wire logic       pop,
	input  wire logic [1:0] action,
	input  wire logic [7:0] left_drive,
	input  wire logic [7:0] right_drive,
	input  wire logic [8:0] line_offset
);

	// A waiting result word must not change or vanish before it is popped.
	`LCS_ASSERT_NEXT(a_word_held, clk, arst_n, !empty && !pop, !empty && $stable(action) && $stable(left_drive) && $stable(right_drive) && $stable(line_offset))

	// A crossing carries no drive and no offset.
	`LCS_ASSERT_NOW(a_crossing_zero, clk, arst_n, !empty && action == 2'd3, left_drive == 8'd0 && right_drive == 8'd0 && line_offset == 9'd0)

	// Reversing drives the wheels with opposite values of the same magnitude.
	`LCS_ASSERT_NOW(a_reverse_mirror, clk, arst_n, !empty && action == 2'd2, line_offset == 9'd0 && left_drive == 8'd0 - right_drive)

	// Steering right comes from a positive offset with a positive first-wheel drive.
	`LCS_ASSERT_NOW(a_right_sign, clk, arst_n, !empty && action == 2'd0, !line_offset[8] && line_offset != 9'd0 && !left_drive[7] && left_drive != 8'd0)

	// Saturation keeps both drives away from the most negative code.
	`LCS_ASSERT_NOW(a_drive_range, clk, arst_n, !empty, left_drive != 8'h80 && right_drive != 8'h80)

endmodule

bind line_centroid_pd_steering_unit lcs_checker u_lcs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.action      (action),
	.left_drive  (left_drive),
	.right_drive (right_drive),
	.line_offset (line_offset)
);

`default_nettype wire
